// ===== rtl/core/ssl_pkg.sv =====
package ssl_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_PRESS  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_CLASSIC = 2'd0,
    MODE_GATE    = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_PITCHED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_LOOP_LENGTH = 2'd0,
    REG_INTENSITY   = 2'd1,
    REG_MIX         = 2'd2,
    REG_PHASE_STEP  = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    WET_DRY   = 2'd0,
    WET_ATTEN = 2'd1,
    WET_GAIN  = 2'd2,
    WET_STORE = 2'd3
  } wet_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_SINE_IDX,
    S_SINE_RD,
    S_FACTOR,
    S_PRODUCT,
    S_ADDR,
    S_MEM,
    S_WET,
    S_MIX,
    S_SUM,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic     wr_en;
    logic     rd_en;
    logic     wet_en;
    wet_sel_t wet_sel;
    logic     prod_en;
    logic     sum_en;
  } lane_ctrl_t;

  localparam longint PI_Q30 = 64'sd3373259426;

  function automatic logic signed [15:0] sine_q15(input longint x, input logic neg);
    longint term;
    longint sum;
    longint r;
    term = x;
    sum  = x;
    term = (term * x) >>> 30;
    term = (term * x) >>> 30;
    term = term / 6;
    sum  = sum - term;
    term = (term * x) >>> 30;
    term = (term * x) >>> 30;
    term = term / 20;
    sum  = sum + term;
    term = (term * x) >>> 30;
    term = (term * x) >>> 30;
    term = term / 42;
    sum  = sum - term;
    term = (term * x) >>> 30;
    term = (term * x) >>> 30;
    term = term / 72;
    sum  = sum + term;
    term = (term * x) >>> 30;
    term = (term * x) >>> 30;
    term = term / 110;
    sum  = sum - term;
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    if (neg) begin
      r = -r;
    end
    return r[15:0];
  endfunction

endpackage

// ===== rtl/core/ssl_sine.sv =====
module ssl_sine #(
  parameter int SINE_ENTRIES = 1024,
  localparam int IW = $clog2(SINE_ENTRIES)
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [IW-1:0]        idx,
  output logic signed [15:0]   value
);
  import ssl_pkg::*;

  localparam int QTR = SINE_ENTRIES / 4;

  logic signed [15:0] rom [SINE_ENTRIES];

  for (genvar i = 0; i < SINE_ENTRIES; i++) begin : g_rom
    localparam longint K = (i < QTR)     ? longint'(i) :
                           (i < 2 * QTR) ? longint'(2 * QTR - i) :
                           (i < 3 * QTR) ? longint'(i - 2 * QTR) :
                                           longint'(SINE_ENTRIES - i);
    localparam longint X = (K * 2 * PI_Q30) / SINE_ENTRIES;
    localparam logic NEG = (i >= 2 * QTR);
    assign rom[i] = sine_q15(X, NEG);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= rom[idx];
    end
  end

endmodule

// ===== rtl/core/ssl_lane.sv =====
module ssl_lane #(
  parameter int MAX_LOOP = 131072,
  localparam int AW = $clog2(MAX_LOOP)
) (
  input  logic                 clk,
  input  ssl_pkg::lane_ctrl_t  ctrl,
  input  logic [AW-1:0]        addr,
  input  logic signed [15:0]   dry,
  input  logic [15:0]          intensity,
  input  logic [15:0]          mix,
  output logic signed [15:0]   result
);
  import ssl_pkg::*;

  logic signed [15:0] store [MAX_LOOP];
  logic signed [15:0] rdata;
  logic signed [17:0] wet;
  logic signed [35:0] pw;
  logic signed [35:0] pd;

  logic signed [17:0] att_g;
  logic signed [17:0] dry_g;
  logic signed [33:0] gain_t;
  logic signed [33:0] att_t;
  logic signed [36:0] sum;
  logic signed [36:0] rs;
  logic signed [17:0] wet_next;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      store[addr] <= dry;
    end
    if (ctrl.rd_en) begin
      rdata <= store[addr];
    end
  end

  always_comb begin
    att_g  = 18'sd32768 - signed'({2'b00, intensity});
    dry_g  = 18'sd32768 - signed'({2'b00, mix});
    gain_t = 34'(rdata) * 34'(signed'({1'b0, intensity})) + 34'sd16384;
    att_t  = 34'(dry) * 34'(att_g) + 34'sd16384;
    unique case (ctrl.wet_sel)
      WET_DRY:   wet_next = 18'(dry);
      WET_ATTEN: wet_next = att_t[32:15];
      WET_GAIN:  wet_next = gain_t[32:15];
      WET_STORE: wet_next = 18'(rdata);
      default:   wet_next = 18'(dry);
    endcase
    sum = 37'(pw) + 37'(pd) + 37'sd16384;
    rs  = sum >>> 15;
  end

  always_ff @(posedge clk) begin
    if (ctrl.wet_en) begin
      wet <= wet_next;
    end
    if (ctrl.prod_en) begin
      pw <= 36'(wet) * 36'(signed'({1'b0, mix}));
      pd <= 36'(dry) * 36'(dry_g);
    end
    if (ctrl.sum_en) begin
      if (rs > 37'sd32767) begin
        result <= 16'sh7fff;
      end else if (rs < -37'sd32768) begin
        result <= 16'sh8000;
      end else begin
        result <= rs[15:0];
      end
    end
  end

endmodule

// ===== rtl/core/ssl_merge.sv =====
module ssl_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic signed [15:0]  left,
  input  logic signed [15:0]  right,
  input  logic                active,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  left_out,
  output logic signed [15:0]  right_out,
  output logic                effect_active
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_out      <= left;
      right_out     <= right;
      effect_active <= active;
    end
  end

endmodule

// ===== rtl/core/stereo_stutter_loop_effect.sv =====
// Stereo stutter effect. Each input transfer carries a command and one stereo
// frame; press, stop and none commands give no result. An audio sample gives
// exactly one result through the shared sequencer, which walks loop position,
// phase index, sine table read, pitch multiply, address reduction, loop memory
// access, gain, mix and saturation while a mode runs, and only gain, mix and
// saturation while the effect is off. Left and right run as two lanes with a
// loop memory of MAX_LOOP samples each; the memory is not cleared and playback
// of a lengthened loop reads stale data. The output register lets the next
// item enter while a result waits.
module stereo_stutter_loop_effect #(
  parameter int MAX_LOOP     = 131072,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic [1:0]          mode,
  input  logic signed [15:0]  left_in,
  input  logic signed [15:0]  right_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  left_out,
  output logic signed [15:0]  right_out,
  output logic                effect_active,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import ssl_pkg::*;

  localparam int AW = $clog2(MAX_LOOP);
  localparam int LW = $clog2(MAX_LOOP + 1);
  localparam int CW = (LW > 17) ? LW : 17;
  localparam int IW = $clog2(SINE_ENTRIES);
  localparam int SW = $clog2(SINE_ENTRIES + 1);

  logic [16:0] loop_length;
  logic [15:0] intensity;
  logic [15:0] mix;
  logic [31:0] phase_step;

  logic          running;
  mode_t         active_mode;
  logic [AW-1:0] loop_position;
  logic          loop_captured;
  logic [31:0]   sine_phase;

  state_t state;
  state_t state_next;

  logic signed [15:0] dl;
  logic signed [15:0] dr;
  logic               pass;
  logic               capture;
  logic               wr_ok;
  logic               gate_open;
  logic [AW-1:0]      p;
  logic [31:0]        phase;
  logic [IW-1:0]      sidx;
  logic [31:0]        factor;
  logic [AW:0]        q;
  logic [AW-1:0]      addr;

  logic signed [15:0] sine_val;
  logic signed [15:0] left_res;
  logic signed [15:0] right_res;
  lane_ctrl_t         ctrl;
  logic               sine_en;
  logic               load;
  logic               ready;

  logic               accept;
  logic [CW-1:0]      ll_w;
  logic [LW-1:0]      len;
  logic               pos_over;
  logic [31+SW:0]     sidx_prod;
  logic signed [33:0] factor_full;
  logic [AW+31:0]     q_prod;
  logic [LW-1:0]      q_w;
  logic [AW-1:0]      rd;
  logic [LW-1:0]      p_inc;
  logic [LW-1:0]      pc;
  logic [AW+15:0]     gate_lhs;
  logic [LW+15:0]     gate_rhs;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    ll_w = CW'(loop_length);
    if (ll_w == '0) begin
      ll_w = CW'(1);
    end else if (ll_w > CW'(MAX_LOOP)) begin
      ll_w = CW'(MAX_LOOP);
    end
    len         = ll_w[LW-1:0];
    pos_over    = LW'(loop_position) >= len;
    sidx_prod   = (32+SW)'(phase) * (32+SW)'(SINE_ENTRIES);
    factor_full = 34'sh80000000
                + 34'(signed'({1'b0, intensity})) * 34'(sine_val);
    q_prod      = (AW+32)'(p) * (AW+32)'(factor);
    q_w         = LW'(q);
    rd          = (q_w >= len) ? AW'(q_w - len) : AW'(q_w);
    p_inc       = LW'(p) + LW'(1);
    pc          = (LW'(loop_position) < len) ? LW'(loop_position) + LW'(1)
                                             : LW'(loop_position);
    gate_lhs    = {1'b0, p, 15'd0};
    gate_rhs    = (LW+16)'(intensity) * (LW+16)'(len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length <= 17'd12000;
      intensity   <= 16'd26214;
      mix         <= 16'd32768;
      phase_step  <= 32'd357913;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_t'(cfg_index))
        REG_LOOP_LENGTH: loop_length <= cfg_data[16:0];
        REG_INTENSITY:   intensity   <= cfg_data[15:0];
        REG_MIX:         mix         <= cfg_data[15:0];
        REG_PHASE_STEP:  phase_step  <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running       <= 1'b0;
      active_mode   <= MODE_CLASSIC;
      loop_position <= '0;
      loop_captured <= 1'b0;
      sine_phase    <= '0;
    end else begin
      state <= state_next;
      if (accept && cmd_t'(command) == CMD_PRESS) begin
        if (running && active_mode == mode_t'(mode)) begin
          running <= 1'b0;
        end else begin
          running     <= 1'b1;
          active_mode <= mode_t'(mode);
        end
        loop_position <= '0;
        loop_captured <= 1'b0;
        sine_phase    <= '0;
      end else if (accept && cmd_t'(command) == CMD_STOP) begin
        running       <= 1'b0;
        loop_position <= '0;
        loop_captured <= 1'b0;
      end else if (state == S_ADDR) begin
        if (active_mode == MODE_GATE) begin
          loop_position <= (p_inc >= len) ? '0 : AW'(p_inc);
        end else if (capture) begin
          if (pc >= len) begin
            loop_captured <= 1'b1;
            loop_position <= '0;
            sine_phase    <= '0;
          end else begin
            loop_position <= AW'(pc);
          end
        end else if (p_inc >= len) begin
          loop_position <= '0;
          sine_phase    <= '0;
        end else begin
          loop_position <= AW'(p_inc);
          sine_phase    <= (active_mode == MODE_PITCHED) ? phase + phase_step : phase;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dl   <= left_in;
      dr   <= right_in;
      pass <= !running;
    end
    if (state == S_POS) begin
      capture <= (active_mode != MODE_GATE) && !loop_captured;
      wr_ok   <= !pos_over;
      p       <= (pos_over && (active_mode == MODE_GATE || loop_captured))
                 ? '0 : loop_position;
      phase   <= (pos_over && loop_captured) ? '0 : sine_phase;
    end
    if (state == S_SINE_IDX) begin
      sidx      <= sidx_prod[32 +: IW];
      gate_open <= (AW+16)'(gate_lhs) < (AW+16)'(gate_rhs)
                   && (LW+16)'(gate_lhs) < gate_rhs;
    end
    if (state == S_FACTOR) begin
      factor <= factor_full[31:0];
    end
    if (state == S_PRODUCT) begin
      q <= q_prod[AW+31:31];
    end
    if (state == S_ADDR) begin
      if (capture) begin
        addr <= loop_position;
      end else begin
        unique case (active_mode)
          MODE_CLASSIC: addr <= p;
          MODE_GATE:    addr <= p;
          MODE_REVERSE: addr <= AW'(len - LW'(1) - LW'(p));
          MODE_PITCHED: addr <= rd;
          default:      addr <= p;
        endcase
      end
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE: begin
        if (accept && cmd_t'(command) == CMD_SAMPLE) begin
          state_next = running ? S_POS : S_WET;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POS:      state_next = S_SINE_IDX;
      S_SINE_IDX: state_next = S_SINE_RD;
      S_SINE_RD:  state_next = S_FACTOR;
      S_FACTOR:   state_next = S_PRODUCT;
      S_PRODUCT:  state_next = S_ADDR;
      S_ADDR:     state_next = S_MEM;
      S_MEM:      state_next = S_WET;
      S_WET:      state_next = S_MIX;
      S_MIX:      state_next = S_SUM;
      S_SUM:      state_next = S_EMIT;
      S_EMIT:     state_next = ready ? S_IDLE : S_EMIT;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.wet_sel = WET_DRY;
    sine_en      = 1'b0;
    load         = 1'b0;
    unique case (state)
      S_SINE_RD: sine_en = 1'b1;
      S_MEM: begin
        ctrl.wr_en = capture && wr_ok;
        ctrl.rd_en = !capture;
      end
      S_WET: begin
        ctrl.wet_en = 1'b1;
        if (pass || capture) begin
          ctrl.wet_sel = WET_DRY;
        end else begin
          unique case (active_mode)
            MODE_CLASSIC: ctrl.wet_sel = WET_GAIN;
            MODE_GATE:    ctrl.wet_sel = gate_open ? WET_DRY : WET_ATTEN;
            MODE_REVERSE: ctrl.wet_sel = WET_STORE;
            MODE_PITCHED: ctrl.wet_sel = WET_STORE;
            default:      ctrl.wet_sel = WET_DRY;
          endcase
        end
      end
      S_MIX:  ctrl.prod_en = 1'b1;
      S_SUM:  ctrl.sum_en  = 1'b1;
      S_EMIT: load         = ready;
      default: ;
    endcase
  end

  ssl_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sine (
    .clk   (clk),
    .en    (sine_en),
    .idx   (sidx),
    .value (sine_val)
  );

  ssl_lane #(.MAX_LOOP(MAX_LOOP)) u_lane_left (
    .clk       (clk),
    .ctrl      (ctrl),
    .addr      (addr),
    .dry       (dl),
    .intensity (intensity),
    .mix       (mix),
    .result    (left_res)
  );

  ssl_lane #(.MAX_LOOP(MAX_LOOP)) u_lane_right (
    .clk       (clk),
    .ctrl      (ctrl),
    .addr      (addr),
    .dry       (dr),
    .intensity (intensity),
    .mix       (mix),
    .result    (right_res)
  );

  ssl_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .left          (left_res),
    .right         (right_res),
    .active        (running),
    .ready         (ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_out      (left_out),
    .right_out     (right_out),
    .effect_active (effect_active)
  );

endmodule

// ===== verif/tb_stereo_stutter_loop_effect.sv =====
module tb_stereo_stutter_loop_effect;
  timeunit 1ns;
  timeprecision 1ps;

  import ssl_pkg::*;

  localparam int LOOP_MAX = 131072;
  localparam int SINE_N = 1024;
  localparam int TAIL_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               active;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = CMD_SAMPLE;
  logic [1:0] mode = MODE_CLASSIC;
  logic signed [15:0] left_in = '0;
  logic signed [15:0] right_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic effect_active;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_LOOP_LENGTH;
  logic [31:0] cfg_data = '0;

  stereo_stutter_loop_effect i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .mode(mode), .left_in(left_in), .right_in(right_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_out(left_out), .right_out(right_out), .effect_active(effect_active),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stutter state and registers as the block should hold them
  logic [16:0] reg_len = 17'd12000;
  logic [15:0] reg_int = 16'd26214;
  logic [15:0] reg_mix = 16'd32768;
  logic [31:0] reg_step = 32'd357913;
  bit          fx_run = 1'b0;
  mode_t       fx_mode = MODE_CLASSIC;
  int unsigned fx_pos = 0;
  bit          fx_cap = 1'b0;
  logic [31:0] fx_phase = '0;
  logic signed [15:0] loop_l [LOOP_MAX];
  logic signed [15:0] loop_r [LOOP_MAX];
  longint sine_tab [SINE_N];

  frame_t expected_frames[$];
  int fails = 0;
  int items_sent = 0;
  int frames_checked = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic longint sine_point(int i);
    int k;
    bit neg;
    longint x, term, sum, rv;
    neg = 1'b0;
    if (i < SINE_N / 4) k = i;
    else if (i < SINE_N / 2) k = SINE_N / 2 - i;
    else if (i < 3 * (SINE_N / 4)) begin
      k = i - SINE_N / 2;
      neg = 1'b1;
    end else begin
      k = SINE_N - i;
      neg = 1'b1;
    end
    x = (longint'(k) * 2 * PI_Q30) / SINE_N;
    term = x;
    sum = x;
    for (int j = 1; j <= 5; j++) begin
      term = (term * x) >>> 30;
      term = (term * x) >>> 30;
      term = term / ((2 * j) * (2 * j + 1));
      if (j % 2 == 1) sum -= term;
      else sum += term;
    end
    if (sum < 0) sum = 0;
    rv = (sum + 16384) >>> 15;
    if (rv > 32767) rv = 32767;
    return neg ? -rv : rv;
  endfunction

  function automatic longint scale_round(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  task automatic predict_frame(cmd_t c, mode_t m, logic signed [15:0] l, logic signed [15:0] r);
    longint dl, dr, wl, wr, g, wet, dry, factor;
    longint unsigned prod;
    int unsigned len, pos, rd;
    frame_t f;
    dl = l;
    dr = r;
    wl = dl;
    wr = dr;
    case (c)
      CMD_PRESS: begin
        if (fx_run && fx_mode == m) fx_run = 1'b0;
        else begin
          fx_run = 1'b1;
          fx_mode = m;
        end
        fx_pos = 0;
        fx_cap = 1'b0;
        fx_phase = '0;
        return;
      end
      CMD_STOP: begin
        fx_run = 1'b0;
        fx_pos = 0;
        fx_cap = 1'b0;
        return;
      end
      CMD_NONE: return;
      default: ;
    endcase
    if (fx_run) begin
      len = (reg_len == 0) ? 1 : reg_len;
      pos = fx_pos;
      if (fx_mode == MODE_GATE) begin
        if (pos >= len) pos = 0;
        if (longint'(pos) * 32768 >= longint'(reg_int) * longint'(len)) begin
          g = 32768 - longint'(reg_int);
          wl = scale_round(dl * g);
          wr = scale_round(dr * g);
        end
        pos++;
        fx_pos = (pos >= len) ? 0 : pos;
      end else if (!fx_cap) begin
        if (pos < len) begin
          loop_l[pos] = l;
          loop_r[pos] = r;
          pos++;
        end
        if (pos >= len) begin
          fx_cap = 1'b1;
          pos = 0;
          fx_phase = '0;
        end
        fx_pos = pos;
      end else begin
        if (pos >= len) begin
          pos = 0;
          fx_phase = '0;
        end
        if (fx_mode == MODE_CLASSIC) begin
          wl = scale_round(longint'(loop_l[pos]) * longint'(reg_int));
          wr = scale_round(longint'(loop_r[pos]) * longint'(reg_int));
        end else begin
          if (fx_mode == MODE_REVERSE) rd = len - 1 - pos;
          else begin
            factor = (longint'(1) << 31) + longint'(reg_int) * sine_tab[fx_phase[31:22]];
            prod = 64'(pos);
            prod = (prod * longint'(factor)) >> 31;
            rd = 32'(prod % len);
          end
          wl = loop_l[rd];
          wr = loop_r[rd];
        end
        pos++;
        if (pos >= len) begin
          pos = 0;
          fx_phase = '0;
        end else if (fx_mode == MODE_PITCHED) begin
          fx_phase = fx_phase + reg_step;
        end
        fx_pos = pos;
      end
    end
    wet = longint'(reg_mix);
    dry = 32768 - wet;
    f.left = clip16(scale_round(wl * wet + dl * dry));
    f.right = clip16(scale_round(wr * wet + dr * dry));
    f.active = fx_run;
    expected_frames.push_back(f);
  endtask

  task automatic send_item(cmd_t c, mode_t m, logic signed [15:0] l, logic signed [15:0] r);
    int gap;
    in_valid <= 1'b1;
    command <= c;
    mode <= m;
    left_in <= l;
    right_in <= r;
    do @(posedge clk); while (in_stall);
    predict_frame(c, m, l, r);
    items_sent++;
    gap = quiet_in ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_samples(int n);
    for (int i = 0; i < n; i++) send_item(CMD_SAMPLE, mode_t'($urandom_range(0, 3)),
                                          rand_sample(), rand_sample());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_frames.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_t idx, logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LOOP_LENGTH: reg_len = val[16:0];
      REG_INTENSITY:   reg_int = val[15:0];
      REG_MIX:         reg_mix = val[15:0];
      REG_PHASE_STEP:  reg_step = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic test_bypass();
    send_item(CMD_SAMPLE, MODE_CLASSIC, 16'sd32767, -16'sd32768);
    send_item(CMD_SAMPLE, MODE_PITCHED, -16'sd32768, 16'sd32767);
    send_item(CMD_NONE, MODE_REVERSE, 16'sd1, -16'sd1);
    send_item(CMD_STOP, MODE_GATE, 16'sd0, 16'sd0);
    send_item(CMD_SAMPLE, MODE_GATE, 16'sd0, -16'sd1);
  endtask

  task automatic test_each_mode();
    write_reg(REG_LOOP_LENGTH, 32'd3);
    write_reg(REG_INTENSITY, 32'd32768);
    write_reg(REG_MIX, 32'd32768);
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    for (int m = 0; m < 4; m++) begin
      send_item(CMD_PRESS, mode_t'(m), 16'sd0, 16'sd0);
      send_samples(4);
      send_item(CMD_PRESS, mode_t'(m), 16'sd0, 16'sd0);
      send_samples(1);
    end
    send_item(CMD_PRESS, MODE_CLASSIC, 16'sd0, 16'sd0);
    send_samples(2);
    send_item(CMD_PRESS, MODE_REVERSE, 16'sd0, 16'sd0);
    send_samples(5);
    send_item(CMD_STOP, MODE_CLASSIC, 16'sd0, 16'sd0);
    send_samples(1);
  endtask

  task automatic test_shortened_loop();
    write_reg(REG_LOOP_LENGTH, 32'd131071);
    write_reg(REG_INTENSITY, 32'd0);
    write_reg(REG_MIX, 32'd65535);
    send_item(CMD_PRESS, MODE_GATE, 16'sd0, 16'sd0);
    send_samples(8);
    send_item(CMD_STOP, MODE_GATE, 16'sd0, 16'sd0);
    send_item(CMD_PRESS, MODE_CLASSIC, 16'sd0, 16'sd0);
    send_samples(8);
    write_reg(REG_LOOP_LENGTH, 32'd5);
    write_reg(REG_INTENSITY, 32'd65535);
    send_samples(8);
    write_reg(REG_LOOP_LENGTH, 32'hFFFE_0001);
    write_reg(REG_MIX, 32'd0);
    send_samples(4);
    send_item(CMD_STOP, MODE_CLASSIC, 16'sd0, 16'sd0);
  endtask

  task automatic test_random_phases(int n);
    int start, count;
    int unsigned len;
    mode_t m;
    start = items_sent;
    while (items_sent - start < n) begin
      quiet_in = ($urandom_range(0, 4) == 0);
      quiet_out = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 7))
        0: len = 0;
        1: len = 1;
        default: len = $urandom_range(2, 48);
      endcase
      write_reg(REG_LOOP_LENGTH, {15'($urandom_range(0, 32767)), len[16:0]});
      case ($urandom_range(0, 3))
        0: write_reg(REG_INTENSITY, $urandom_range(0, 1) ? 32'd0 : 32'd32768);
        1: write_reg(REG_INTENSITY, $urandom);
        2: write_reg(REG_INTENSITY, $urandom_range(0, 32768));
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_MIX, $urandom_range(0, 1) ? 32'd0 : 32'd32768);
        1: write_reg(REG_MIX, $urandom);
        2: write_reg(REG_MIX, $urandom_range(0, 32768));
        default: ;
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(REG_PHASE_STEP, 32'd0);
        1: write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        2: write_reg(REG_PHASE_STEP,
                     32'(33'h1_0000_0000 / 33'((len == 0) ? 1 : len)));
        3: write_reg(REG_PHASE_STEP, $urandom);
        default: ;
      endcase
      m = mode_t'($urandom_range(0, 3));
      send_item(CMD_PRESS, m, rand_sample(), rand_sample());
      count = $urandom_range(len, 3 * len + 5);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 14) == 0) send_item(cmd_t'($urandom_range(1, 3)),
            mode_t'($urandom_range(0, 3)), rand_sample(), rand_sample());
        else send_samples(1);
      end
      send_item(CMD_STOP, mode_t'($urandom_range(0, 3)), rand_sample(), rand_sample());
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    frame_t exp_f;
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected result: left_out %0d right_out %0d", left_out, right_out);
        fails++;
      end else begin
        exp_f = expected_frames.pop_front();
        frames_checked++;
        if (left_out !== exp_f.left) begin
          $error("left_out: expected %0d, got %0d", exp_f.left, left_out);
          fails++;
        end
        if (right_out !== exp_f.right) begin
          $error("right_out: expected %0d, got %0d", exp_f.right, right_out);
          fails++;
        end
        if (effect_active !== exp_f.active) begin
          $error("effect_active: expected %0d, got %0d", exp_f.active, effect_active);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < SINE_N; i++) sine_tab[i] = sine_point(i);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_bypass();
    test_each_mode();
    test_shortened_loop();
    test_random_phases(RANDOM_ITEMS);
    drain();
    $display("Sent %0d items and checked %0d frames over %0d register writes,",
             items_sent, frames_checked, cfg_writes);
    $display("covering all four modes, toggles, stops and shortened loops.");
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
